// ===== design/fme_pkg.sv =====
package fme_pkg;

  // Membership degree of 1.0 in Q1.15.
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SHAPE   = 3'd0,
    CFG_POINT_A = 3'd1,
    CFG_POINT_B = 3'd2,
    CFG_POINT_C = 3'd3,
    CFG_POINT_D = 3'd4
  } cfg_idx_e;

  // Curve selection codes.
  typedef enum logic [2:0] {
    SHP_RAMP_UP    = 3'd0,
    SHP_RAMP_DOWN  = 3'd1,
    SHP_TRIANGLE   = 3'd2,
    SHP_TRAPEZOID  = 3'd3,
    SHP_S_CURVE    = 3'd4,
    SHP_Z_CURVE    = 3'd5,
    SHP_SMOOTH_TRI = 3'd6,
    SHP_SMOOTH_TRAP = 3'd7
  } shape_e;

  // How the final degree is formed once the edge fraction is known.
  typedef enum logic [1:0] {
    MODE_ZERO   = 2'd0,
    MODE_ONE    = 2'd1,
    MODE_LINEAR = 2'd2,
    MODE_SMOOTH = 2'd3
  } mode_e;

endpackage

// ===== design/fuzzy_membership_evaluator.sv =====
// Channel   Direction  Handshake                          Payload
// cfg       in         cfg_valid_i / cfg_ready_o          cfg_index_i, cfg_data_i
// sample    in         sample_valid_i / sample_ready_o    sample_i
// degree    out        degree_valid_o / degree_ready_i    degree_o
//
// Every item passes six register stages: one select stage, four divider stages
// of four restoring steps each, and one table/format stage. An accepted item
// moves through the select and divider stages into the output register.
// A new item is accepted in every cycle in which the pipeline advances.
// The whole pipeline advances together; when the output item is not taken,
// every stage holds, so nothing is lost or repeated. The configuration port
// is always ready. Reset clears the valid bits and loads the register defaults.
module fuzzy_membership_evaluator
  import fme_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [SAMPLE_WIDTH-1:0] cfg_data_i,
  input  logic                    sample_valid_i,
  output logic                    sample_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    degree_valid_o,
  input  logic                    degree_ready_i,
  output logic [15:0]             degree_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int NDIV  = 4;   // divider stages
  localparam int STEPS = 4;   // restoring steps per divider stage
  localparam int LOG2D = $clog2(COS_TABLE_DEPTH);
  localparam int SHIFT = 14 - LOG2D;
  localparam int HALF_DEPTH = COS_TABLE_DEPTH / 2;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  // Taylor term divisors (2n-1)*(2n) for n = 1..12.
  localparam longint unsigned TAYLOR_DIV [1:12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  typedef logic [15:0] cos_tab_t [0:COS_TABLE_DEPTH];

  // Raised-cosine table h(k/D) = 0.5*(1+cos(pi*k/D)) in Q1.15, built at
  // elaboration from a Taylor series in Q30.
  function automatic cos_tab_t build_table();
    cos_tab_t t;
    longint unsigned x, x2, term;
    longint sum;
    for (int k = 0; k <= HALF_DEPTH; k++) begin
      x    = (PI_Q30 * longint'(k)) >> LOG2D;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = longint'(Q30_ONE);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      t[k] = 16'((Q30_ONE + longint'(sum) + 64'd32768) >> 16);
    end
    for (int k = HALF_DEPTH + 1; k <= COS_TABLE_DEPTH; k++) begin
      t[k] = ONE_Q15 - t[COS_TABLE_DEPTH - k];
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_table();

  // Configuration registers.
  logic [2:0]    shape_q;
  logic [SW-1:0] pa_q, pb_q, pc_q, pd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHP_TRIANGLE;
      pa_q    <= '0;
      pb_q    <= SW'(16384);
      pc_q    <= SW'(16384);
      pd_q    <= SW'(32767);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SHAPE:   shape_q <= cfg_data_i[2:0];
        CFG_POINT_A: pa_q    <= cfg_data_i;
        CFG_POINT_B: pb_q    <= cfg_data_i;
        CFG_POINT_C: pc_q    <= cfg_data_i;
        CFG_POINT_D: pd_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register is free or drained.
  logic advance;
  assign advance        = !degree_valid_o || degree_ready_i;
  assign sample_ready_o = advance;

  // Stage 0: decide the branch and form the edge numerator and span.
  logic signed [SW-1:0] u, a, b, c, d;
  mode_e                sel_mode;
  logic [SW-1:0]        sel_num, sel_den;
  mode_e                mode_s0;

  assign u = sample_i;
  assign a = pa_q;
  assign b = pb_q;
  assign c = pc_q;
  assign d = pd_q;

  // Difference of two breakpoints or samples; the branch tests keep it >= 0.
  function automatic logic [SW-1:0] dif(logic signed [SW-1:0] x, logic signed [SW-1:0] y);
    logic signed [SW:0] r;
    r = {x[SW-1], x} - {y[SW-1], y};
    return r[SW-1:0];
  endfunction

  always_comb begin
    sel_mode = MODE_ZERO;
    sel_num  = '0;
    sel_den  = '0;
    case (shape_e'(shape_q))
      SHP_RAMP_UP, SHP_S_CURVE: begin
        if (u > b) sel_mode = MODE_ONE;
        else if (u < a) sel_mode = MODE_ZERO;
        else begin
          sel_mode = (shape_q == SHP_S_CURVE) ? MODE_SMOOTH : MODE_LINEAR;
          sel_num  = (shape_q == SHP_S_CURVE) ? dif(b, u) : dif(u, a);
          sel_den  = dif(b, a);
        end
      end
      SHP_RAMP_DOWN, SHP_Z_CURVE: begin
        if (u > b) sel_mode = MODE_ZERO;
        else if (u < a) sel_mode = MODE_ONE;
        else begin
          sel_mode = (shape_q == SHP_Z_CURVE) ? MODE_SMOOTH : MODE_LINEAR;
          sel_num  = (shape_q == SHP_Z_CURVE) ? dif(u, a) : dif(b, u);
          sel_den  = dif(b, a);
        end
      end
      SHP_TRIANGLE: begin
        if (u < a || u > c) sel_mode = MODE_ZERO;
        else if (u < b) begin
          sel_mode = MODE_LINEAR;
          sel_num  = dif(u, a);
          sel_den  = dif(b, a);
        end else begin
          sel_mode = MODE_LINEAR;
          sel_num  = dif(c, u);
          sel_den  = dif(c, b);
        end
      end
      SHP_SMOOTH_TRI: begin
        if (u < a || u > c) sel_mode = MODE_ZERO;
        else if (u < b) begin
          sel_mode = MODE_SMOOTH;
          sel_num  = dif(b, u);
          sel_den  = dif(b, a);
        end else begin
          sel_mode = MODE_SMOOTH;
          sel_num  = dif(u, b);
          sel_den  = dif(c, b);
        end
      end
      default: begin
        // Both trapezoid forms.
        if (u < a || u > d) sel_mode = MODE_ZERO;
        else if (b <= u && u <= c) sel_mode = MODE_ONE;
        else if (u < b) begin
          sel_mode = (shape_q == SHP_SMOOTH_TRAP) ? MODE_SMOOTH : MODE_LINEAR;
          sel_num  = (shape_q == SHP_SMOOTH_TRAP) ? dif(b, u) : dif(u, a);
          sel_den  = dif(b, a);
        end else if (c < u) begin
          sel_mode = (shape_q == SHP_SMOOTH_TRAP) ? MODE_SMOOTH : MODE_LINEAR;
          sel_num  = (shape_q == SHP_SMOOTH_TRAP) ? dif(u, c) : dif(d, u);
          sel_den  = dif(d, c);
        end else sel_mode = MODE_ZERO;
      end
    endcase
    // A zero-width edge is treated as fully inside.
    mode_s0 = sel_mode;
    if ((sel_mode == MODE_LINEAR || sel_mode == MODE_SMOOTH) && sel_den == '0) begin
      mode_s0 = MODE_ONE;
    end
  end

  // Stage registers: index 0 is the select stage, 1..NDIV the divider stages.
  logic  [NDIV:0] vld_q;
  mode_e          mode_q [0:NDIV];
  logic [SW:0]    rem_q  [0:NDIV];
  logic [SW-1:0]  den_q  [0:NDIV];
  logic [15:0]    quo_q  [0:NDIV];
  logic [SW:0]    rem_n  [1:NDIV];
  logic [15:0]    quo_n  [1:NDIV];

  // Restoring division: degree fraction = floor(num * 2^15 / den), num <= den.
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [SW:0] rem_d;
    logic [15:0] quo_d;

    always_comb begin
      rem_d = rem_q[k-1];
      quo_d = quo_q[k-1];
      for (int j = 0; j < STEPS; j++) begin
        if (rem_d >= {1'b0, den_q[k-1]}) begin
          quo_d[15 - ((k - 1) * STEPS + j)] = 1'b1;
          rem_d = rem_d - {1'b0, den_q[k-1]};
        end
        rem_d = {rem_d[SW-1:0], 1'b0};
      end
    end

    assign rem_n[k] = rem_d;
    assign quo_n[k] = quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NDIV-1:0], sample_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_q[0] <= mode_s0;
      rem_q[0]  <= {1'b0, sel_num};
      den_q[0]  <= sel_den;
      quo_q[0]  <= '0;
      for (int k = 1; k <= NDIV; k++) begin
        mode_q[k] <= mode_q[k-1];
        rem_q[k]  <= rem_n[k];
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= quo_n[k];
      end
    end
  end

  // Last stage: linear degree is the quotient itself; a smooth edge rounds the
  // fraction to the nearest table index and reads the raised cosine.
  logic [LOG2D+1:0] idx_2x;
  logic [LOG2D:0]   tab_idx;
  logic [15:0]      degree_d, degree_q;
  logic             out_vld_q;

  assign idx_2x  = (LOG2D + 2)'(quo_q[NDIV] >> SHIFT);
  assign tab_idx = (LOG2D + 1)'((idx_2x + 1'b1) >> 1);

  always_comb begin
    case (mode_q[NDIV])
      MODE_ZERO:   degree_d = '0;
      MODE_ONE:    degree_d = ONE_Q15;
      MODE_LINEAR: degree_d = quo_q[NDIV];
      default:     degree_d = COS_TAB[tab_idx];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= vld_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      degree_q <= degree_d;
    end
  end

  assign degree_valid_o = out_vld_q;
  assign degree_o       = degree_q;

  // The degree never exceeds 1.0.
  a_degree_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    degree_valid_o |-> degree_o <= ONE_Q15)
    else $error("degree above 1.0");

  // After the divider the remainder stays below twice the span.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NDIV] && (mode_q[NDIV] == MODE_LINEAR || mode_q[NDIV] == MODE_SMOOTH))
      |-> rem_q[NDIV] < {den_q[NDIV], 1'b0})
    else $error("divider remainder out of range");

  // A smooth index never runs past the end of the table.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NDIV] && mode_q[NDIV] == MODE_SMOOTH) |-> tab_idx <= (LOG2D + 1)'(COS_TABLE_DEPTH))
    else $error("table index out of range");

  // A stalled output item is held by the whole pipeline.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (degree_valid_o && !degree_ready_i) |=> (vld_q == $past(vld_q)))
    else $error("pipeline moved during a stall");

endmodule
